/* rtl/bba_pkg.sv */
// shared types and codes for the best bid/ask price book
package bba_pkg;

    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SWEEP = 3'd2;
    localparam logic [2:0] ST_LAST  = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    typedef struct packed {
        logic valid;
        logic side;
        logic op;
    } req_ctl_t;

endpackage

/* rtl/bba_front.sv */
// request intake: classifies each request and holds it in a two-entry queue
module bba_front #(
    parameter int PRICE_BITS = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [PRICE_BITS-1:0]   s_price,
    input  logic                    s_side,
    input  logic                    s_remove,
    input  logic                    init_done,
    output bba_pkg::req_ctl_t       q_ctl,
    output logic [PRICE_BITS-1:0]   q_price,
    input  logic                    q_pop
);
    import bba_pkg::*;

    logic [PRICE_BITS-1:0] price_reg [2];
    logic                  side_reg  [2];
    logic                  op_reg    [2];
    logic                  wr_ptr_reg, wr_ptr_next;
    logic                  rd_ptr_reg, rd_ptr_next;
    logic [1:0]            count_reg, count_next;
    logic                  push;
    logic                  pop;

    assign s_tready = init_done && (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && (count_reg != 2'd0);

    assign q_ctl.valid = (count_reg != 2'd0);
    assign q_ctl.side  = side_reg[rd_ptr_reg];
    assign q_ctl.op    = op_reg[rd_ptr_reg];
    assign q_price     = price_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            price_reg[wr_ptr_reg] <= s_price;
            side_reg[wr_ptr_reg]  <= s_side ? SIDE_SELL : SIDE_BUY;
            op_reg[wr_ptr_reg]    <= s_remove ? OP_REMOVE : OP_APPEND;
        end
    end

endmodule

/* rtl/bba_back.sv */
// update engine: sweeps both side memories, applies the request, tracks best prices
module bba_back #(
    parameter int SIDE_DEPTH = 64,
    parameter int PRICE_BITS = 32,
    parameter int DATA_W     = 104
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  bba_pkg::req_ctl_t       q_ctl,
    input  logic [PRICE_BITS-1:0]   q_price,
    output logic                    q_pop,
    output logic                    init_done,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [DATA_W-1:0]       m_tdata,
    output logic [2:0]              m_tuser
);
    import bba_pkg::*;

    localparam int AW = $clog2(SIDE_DEPTH);
    localparam int P  = PRICE_BITS;
    localparam logic [AW-1:0] LAST_IDX = AW'(SIDE_DEPTH - 1);

    // entry layout: used bit on top of the price
    logic [P:0] bid_mem [SIDE_DEPTH];
    logic [P:0] ask_mem [SIDE_DEPTH];
    logic [P:0] bid_rd_reg, ask_rd_reg;

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic          rd_valid_reg, rd_valid_next;
    logic [AW-1:0] rd_idx_reg;

    logic          item_side_reg, item_side_next;
    logic          item_op_reg, item_op_next;
    logic [P-1:0]  item_price_reg, item_price_next;
    logic          found_free_reg, found_free_next;
    logic [P-1:0]  best_bid_reg, best_bid_next;
    logic          bid_any_reg, bid_any_next;
    logic [P-1:0]  best_ask_reg, best_ask_next;
    logic          ask_any_reg, ask_any_next;

    logic              m_valid_reg, m_valid_next;
    logic [DATA_W-1:0] m_data_reg, m_data_next;
    logic [2:0]        m_user_reg, m_user_next;
    logic              load_out;

    logic          clr_we;
    logic          bid_we, ask_we;
    logic [P:0]    bid_wd, ask_wd;
    logic [AW-1:0] wr_addr;
    logic          bid_used_post, ask_used_post;
    logic [P-1:0]  bid_val, ask_val;
    logic [P:0]    mid_sum;

    assign init_done = (state_reg != ST_CLEAR);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_user_reg;
    assign wr_addr   = clr_we ? idx_reg : rd_idx_reg;

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        rd_valid_next   = 1'b0;
        q_pop           = 1'b0;
        clr_we          = 1'b0;
        load_out        = 1'b0;
        item_side_next  = item_side_reg;
        item_op_next    = item_op_reg;
        item_price_next = item_price_reg;
        found_free_next = found_free_reg;
        best_bid_next   = best_bid_reg;
        bid_any_next    = bid_any_reg;
        best_ask_next   = best_ask_reg;
        ask_any_next    = ask_any_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                clr_we = 1'b1;
                if (idx_reg == LAST_IDX) begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (q_ctl.valid) begin
                    q_pop           = 1'b1;
                    item_side_next  = q_ctl.side;
                    item_op_next    = q_ctl.op;
                    item_price_next = q_price;
                    found_free_next = 1'b0;
                    best_bid_next   = '0;
                    bid_any_next    = 1'b0;
                    best_ask_next   = '0;
                    ask_any_next    = 1'b0;
                    idx_next        = '0;
                    state_next      = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                rd_valid_next = 1'b1;
                if (idx_reg == LAST_IDX) begin
                    idx_next   = '0;
                    state_next = ST_LAST;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_LAST: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // apply the request to the slot read last cycle
        bid_used_post = bid_rd_reg[P];
        bid_val       = bid_rd_reg[P-1:0];
        ask_used_post = ask_rd_reg[P];
        ask_val       = ask_rd_reg[P-1:0];
        bid_we        = clr_we;
        ask_we        = clr_we;
        bid_wd        = '0;
        ask_wd        = '0;
        if (rd_valid_reg) begin
            if (item_side_reg == SIDE_BUY) begin
                if (item_op_reg == OP_REMOVE) begin
                    if (bid_used_post && (bid_val == item_price_reg)) begin
                        bid_used_post = 1'b0;
                        bid_we        = 1'b1;
                        bid_wd        = {1'b0, bid_val};
                    end
                end else if (!bid_used_post && !found_free_reg) begin
                    bid_used_post   = 1'b1;
                    bid_val         = item_price_reg;
                    bid_we          = 1'b1;
                    bid_wd          = {1'b1, item_price_reg};
                    found_free_next = 1'b1;
                end
            end else begin
                if (item_op_reg == OP_REMOVE) begin
                    if (ask_used_post && (ask_val == item_price_reg)) begin
                        ask_used_post = 1'b0;
                        ask_we        = 1'b1;
                        ask_wd        = {1'b0, ask_val};
                    end
                end else if (!ask_used_post && !found_free_reg) begin
                    ask_used_post   = 1'b1;
                    ask_val         = item_price_reg;
                    ask_we          = 1'b1;
                    ask_wd          = {1'b1, item_price_reg};
                    found_free_next = 1'b1;
                end
            end
            if (bid_used_post && (!bid_any_reg || (bid_val > best_bid_reg))) begin
                best_bid_next = bid_val;
                bid_any_next  = 1'b1;
            end
            if (ask_used_post && (!ask_any_reg || (ask_val < best_ask_reg))) begin
                best_ask_next = ask_val;
                ask_any_next  = 1'b1;
            end
        end

        mid_sum = (bid_any_reg && ask_any_reg)
                ? ({1'b0, best_bid_reg} + {1'b0, best_ask_reg}) : '0;

        m_data_next = m_data_reg;
        m_user_next = m_user_reg;
        if (load_out) begin
            m_data_next          = '0;
            m_data_next[3*P:0]   = {mid_sum, best_ask_reg, best_bid_reg};
            m_user_next          = {(item_op_reg == OP_APPEND) && !found_free_reg,
                                    ask_any_reg, bid_any_reg};
        end

        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (load_out) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            idx_reg      <= '0;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            rd_valid_reg <= rd_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg     <= idx_reg;
        item_side_reg  <= item_side_next;
        item_op_reg    <= item_op_next;
        item_price_reg <= item_price_next;
        found_free_reg <= found_free_next;
        best_bid_reg   <= best_bid_next;
        bid_any_reg    <= bid_any_next;
        best_ask_reg   <= best_ask_next;
        ask_any_reg    <= ask_any_next;
        m_data_reg     <= m_data_next;
        m_user_reg     <= m_user_next;
    end

    always_ff @(posedge aclk) begin
        bid_rd_reg <= bid_mem[idx_reg];
        ask_rd_reg <= ask_mem[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (bid_we) begin
            bid_mem[wr_addr] <= bid_wd;
        end
        if (ask_we) begin
            ask_mem[wr_addr] <= ask_wd;
        end
    end

endmodule

/* rtl/price_book_best_bid_ask.sv */
// top level of the best bid/ask price book
// each request is applied in a one-slot-a-cycle sweep of the two side memories;
// requests are processed one at a time, and the two-entry front queue holds
//   further requests meanwhile
// reset: after aresetn a clearing pass over every slot empties both sides;
//   s_tready stays low during it
module price_book_best_bid_ask #(
    parameter int SIDE_DEPTH = 64,
    parameter int PRICE_BITS = 32
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    input  logic [((PRICE_BITS+7)/8)*8-1:0]           s_tdata,  // price
    input  logic [1:0]                                s_tuser,  // side, remove
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    output logic [((3*PRICE_BITS+1+7)/8)*8-1:0]       m_tdata,  // best_bid, best_ask, mid_doubled
    output logic [2:0]                                m_tuser   // bid_present, ask_present, dropped
);
    import bba_pkg::*;

    localparam int OUT_W = ((3*PRICE_BITS+1+7)/8)*8;

    req_ctl_t              q_ctl;
    logic [PRICE_BITS-1:0] q_price;
    logic                  q_pop;
    logic                  init_done;

    bba_front #(
        .PRICE_BITS(PRICE_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_price   (s_tdata[PRICE_BITS-1:0]),
        .s_side    (s_tuser[0]),
        .s_remove  (s_tuser[1]),
        .init_done (init_done),
        .q_ctl     (q_ctl),
        .q_price   (q_price),
        .q_pop     (q_pop)
    );

    bba_back #(
        .SIDE_DEPTH(SIDE_DEPTH),
        .PRICE_BITS(PRICE_BITS),
        .DATA_W    (OUT_W)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_ctl     (q_ctl),
        .q_price   (q_price),
        .q_pop     (q_pop),
        .init_done (init_done),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

/* rtl/bba_checker.sv */
// port-level checks for the best bid/ask price book, bound to the top level
module bba_checker #(
    parameter int PRICE_BITS = 32
) (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_tvalid,
    input logic                                  s_tready,
    input logic [((PRICE_BITS+7)/8)*8-1:0]       s_tdata,
    input logic [1:0]                            s_tuser,
    input logic                                  m_tvalid,
    input logic                                  m_tready,
    input logic [((3*PRICE_BITS+1+7)/8)*8-1:0]   m_tdata,
    input logic [2:0]                            m_tuser
);
    localparam int P = PRICE_BITS;

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s_tready)
        else $error("outputs active right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (!m_tuser[0] || !m_tuser[1]) |->
            (m_tdata[3*P:2*P] == '0) &&
            (m_tuser[0] || (m_tdata[P-1:0] == '0)) &&
            (m_tuser[1] || (m_tdata[2*P-1:P] == '0)))
        else $error("empty side reports a nonzero price");

    a_drop_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2] |-> m_tuser[0] || m_tuser[1])
        else $error("drop reported with both sides empty");

endmodule

bind price_book_best_bid_ask bba_checker #(.PRICE_BITS(PRICE_BITS)) u_bba_checker (.*);
